### rtl/rowqs_pkg.sv
// Package for the read-over-write quantum scheduler.
// Holds the sizes, action codes, sequencer states and register indexes.
// No dependencies.
`default_nettype none
package rowqs_pkg;
   localparam int NQ                = 7;
   localparam int QUEUE_DEPTH       = 16;
   localparam int READ_WINDOW_TICKS = 70;
   localparam int PTR_W             = $clog2(QUEUE_DEPTH);
   localparam int CNT_W             = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W            = $clog2(NQ * QUEUE_DEPTH);
   localparam int QNUM_W            = 3;
   localparam int TAG_W             = 16;
   localparam int QUANT_W           = 10;
   localparam int WAIT_W            = 16;
   localparam int TIME_W            = 32;
   localparam int PADDR_W           = 5;

   localparam logic [QUANT_W-1:0] DISP_MAX = 10'd1023;
   localparam logic [QUANT_W-1:0] QUANTUM_RESET [NQ] =
      '{10'd100, 10'd100, 10'd2, 10'd1, 10'd1, 10'd1, 10'd1};
   localparam logic [WAIT_W-1:0]  IDLE_WAIT_RESET = 16'd50;

   localparam logic [2:0] REG_IDLE_WAIT = 3'd7;

   typedef enum logic [1:0] {
      ACT_ADD      = 2'd0,
      ACT_DISPATCH = 2'd1,
      ACT_TICK     = 2'd2,
      ACT_NOP      = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_QUANT,
      ST_PICK,
      ST_READ,
      ST_GRANT,
      ST_RESP
   } state_type;
endpackage
`default_nettype wire

### rtl/rowqs_req_if.sv
// Request channel of the scheduler: valid/ready plus the item fields.
// Depends on rowqs_pkg.
`default_nettype none
interface rowqs_req_if import rowqs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        action;
   logic [2:0]        queue_class;
   logic [TAG_W-1:0]  request_tag;
   modport source (output valid, action, queue_class, request_tag, input ready);
   modport sink   (input valid, action, queue_class, request_tag, output ready);
endinterface
`default_nettype wire

### rtl/rowqs_rsp_if.sv
// Result channel of the scheduler: valid/ready plus the result fields.
// Depends on rowqs_pkg.
`default_nettype none
interface rowqs_rsp_if import rowqs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              grant_valid;
   logic [TAG_W-1:0]  grant_tag;
   logic [2:0]        grant_class;
   logic              idle_hold;
   logic              add_rejected;
   modport source (output valid, grant_valid, grant_tag, grant_class, idle_hold,
                   add_rejected, input ready);
   modport sink   (input valid, grant_valid, grant_tag, grant_class, idle_hold,
                   add_rejected, output ready);
endinterface
`default_nettype wire

### rtl/read_over_write_quantum_scheduler_core.sv
// Read-over-write quantum scheduler: seven tag FIFOs, quantum round robin,
// read idling. Depends on rowqs_pkg, rowqs_req_if and rowqs_rsp_if.
//
// Usage:
//  - req_ch carries one item: add (queue_class, request_tag), dispatch or tick.
//    rsp_ch returns exactly one result item per request item.
//  - The block takes one item at a time; req_ch.ready is high only while it
//    is idle and no result is waiting.
//  - Add and tick: work in the accept cycle, result valid the next cycle.
//  - Dispatch: the sequencer checks one queue per cycle with a single
//    compare unit, in order: accept, unserved scan, quantum check, round
//    robin hops, tag memory read and retire; an idle hold ends at the
//    quantum check, a grant goes through the registered tag memory read.
//  - The result stays in its output register while rsp_ch.ready is low; no
//    new item is taken until it is delivered.
//  - Reset (synchronous, active high) empties all queues, restores the
//    register defaults and needs no clearing pass; the tag memory is only
//    read at entries written earlier.
//  - APB registers 0..7 at byte address 4*i: seven quanta, then the idle wait.
`default_nettype none
module read_over_write_quantum_scheduler_core import rowqs_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   rowqs_req_if.sink               req_ch,
   rowqs_rsp_if.source             rsp_ch,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [31:0]        pwdata,
   output logic      [31:0]        prdata,
   output logic                    pready
);
   state_type state_ff, state_in;

   logic [QUANT_W-1:0] quantum_ff [NQ];
   logic [WAIT_W-1:0]  idle_wait_ff;

   logic [TAG_W-1:0]   tag_mem [NQ*QUEUE_DEPTH];
   logic [TAG_W-1:0]   rd_data_ff;

   logic [PTR_W-1:0]   head_ff [NQ], head_in [NQ];
   logic [CNT_W-1:0]   count_ff [NQ], count_in [NQ];
   logic [QUANT_W-1:0] disp_ff [NQ], disp_in [NQ];
   logic [2:0]         cq_ff, cq_in;
   logic [2:0]         start_ff, start_in;
   logic [2:0]         scan_ff, scan_in;
   logic [NQ-1:0]      marks_ff, marks_in;
   logic [1:0]         armed_ff, armed_in;
   logic [TIME_W-1:0]  wend_ff [2], wend_in [2];
   logic [TIME_W-1:0]  time_ff, time_in;
   logic               pending_ff, pending_in;
   logic [WAIT_W-1:0]  cd_ff, cd_in;

   logic               gv_ff, gv_in;
   logic [TAG_W-1:0]   gtag_ff, gtag_in;
   logic [2:0]         gcls_ff, gcls_in;
   logic               hold_ff, hold_in;
   logic               rej_ff, rej_in;

   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [ADDR_W-1:0]  mem_raddr;

   logic               cfg_we;
   logic [2:0]         cfg_idx;

   assign pready  = 1'b1;
   assign cfg_idx = paddr[4:2];
   assign cfg_we  = psel && penable && pwrite;

   always_comb begin
      if (cfg_idx == REG_IDLE_WAIT) begin
         prdata = {{(32-WAIT_W){1'b0}}, idle_wait_ff};
      end else begin
         prdata = {{(32-QUANT_W){1'b0}}, quantum_ff[cfg_idx]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NQ; i++) quantum_ff[i] <= QUANTUM_RESET[i];
         idle_wait_ff <= IDLE_WAIT_RESET;
      end else if (cfg_we) begin
         if (cfg_idx == REG_IDLE_WAIT) begin
            idle_wait_ff <= pwdata[WAIT_W-1:0];
         end else begin
            quantum_ff[cfg_idx] <= pwdata[QUANT_W-1:0];
         end
      end
   end

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = (state_ff == ST_RESP);
   assign rsp_ch.grant_valid  = gv_ff;
   assign rsp_ch.grant_tag    = gtag_ff;
   assign rsp_ch.grant_class  = gcls_ff;
   assign rsp_ch.idle_hold    = hold_ff;
   assign rsp_ch.add_rejected = rej_ff;

   always_comb begin
      logic              any_pending;
      logic [2:0]        nq;
      logic [2:0]        c;
      logic [PTR_W:0]    wsum;
      logic [PTR_W-1:0]  wptr;
      logic [WAIT_W-1:0] cd_next;
      logic [TIME_W-1:0] tdiff;

      any_pending = 1'b0;
      for (int i = 0; i < NQ; i++) any_pending = any_pending || (count_ff[i] != '0);

      state_in   = state_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      disp_in    = disp_ff;
      cq_in      = cq_ff;
      start_in   = start_ff;
      scan_in    = scan_ff;
      marks_in   = marks_ff;
      armed_in   = armed_ff;
      wend_in    = wend_ff;
      time_in    = time_ff;
      pending_in = pending_ff;
      cd_in      = cd_ff;
      gv_in      = gv_ff;
      gtag_in    = gtag_ff;
      gcls_in    = gcls_ff;
      hold_in    = hold_ff;
      rej_in     = rej_ff;
      mem_we     = 1'b0;
      c          = req_ch.queue_class;
      wsum       = {1'b0, head_ff[c[2:0] == 3'd7 ? 3'd0 : c]} +
                   (PTR_W+1)'(count_ff[c[2:0] == 3'd7 ? 3'd0 : c]);
      wptr       = (wsum >= (PTR_W+1)'(QUEUE_DEPTH)) ?
                   PTR_W'(wsum - (PTR_W+1)'(QUEUE_DEPTH)) : wsum[PTR_W-1:0];
      mem_waddr  = ADDR_W'(c) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(wptr);
      mem_raddr  = ADDR_W'(cq_ff) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_ff[cq_ff]);
      nq         = (cq_ff == 3'(NQ-1)) ? 3'd0 : cq_ff + 3'd1;
      cd_next    = (cd_ff != '0) ? cd_ff - 1'b1 : cd_ff;
      tdiff      = time_ff - wend_ff[c[0]];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               gv_in   = 1'b0;
               gtag_in = '0;
               gcls_in = '0;
               hold_in = 1'b0;
               rej_in  = 1'b0;
               state_in = ST_RESP;
               case (action_type'(req_ch.action))
                  ACT_ADD: begin
                     if (c == 3'd7 || count_ff[c] >= CNT_W'(QUEUE_DEPTH)) begin
                        rej_in = 1'b1;
                     end else begin
                        mem_we      = 1'b1;
                        count_in[c] = count_ff[c] + 1'b1;
                        if (c < 3'd2) begin
                           pending_in     = 1'b0;
                           cd_in          = '0;
                           armed_in[c[0]] = tdiff[TIME_W-1];
                           wend_in[c[0]]  = time_ff + TIME_W'(READ_WINDOW_TICKS);
                        end
                     end
                  end
                  ACT_DISPATCH: begin
                     scan_in  = 3'd0;
                     state_in = ST_SCAN;
                  end
                  ACT_TICK: begin
                     time_in = time_ff + 1'b1;
                     if (pending_ff) begin
                        cd_in = cd_next;
                        if (cd_next == '0) begin
                           pending_in = 1'b0;
                           if (cq_ff < 3'd2) armed_in[cq_ff[0]] = 1'b0;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // unserved queues ahead of the current one win back first
            if (scan_ff >= cq_ff) begin
               state_in = ST_QUANT;
            end else if (marks_ff[scan_ff] && count_ff[scan_ff] != '0) begin
               cq_in    = scan_ff;
               state_in = ST_READ;
            end else begin
               scan_in = scan_ff + 3'd1;
            end
         end
         ST_QUANT: begin
            start_in = cq_ff;
            if (disp_ff[cq_ff] >= quantum_ff[cq_ff]) begin
               disp_in[cq_ff] = '0;
               state_in = any_pending ? ST_PICK : ST_RESP;
            end else if (count_ff[cq_ff] == '0) begin
               if (pending_ff) begin
                  hold_in  = 1'b1;
                  state_in = ST_RESP;
               end else if (cq_ff < 3'd2 && armed_ff[cq_ff[0]]) begin
                  pending_in = 1'b1;
                  cd_in      = (idle_wait_ff != '0) ? idle_wait_ff : WAIT_W'(1);
                  hold_in    = 1'b1;
                  state_in   = ST_RESP;
               end else begin
                  state_in = any_pending ? ST_PICK : ST_RESP;
               end
            end else begin
               state_in = ST_READ;
            end
         end
         ST_PICK: begin
            // one round robin hop per cycle; wrapping opens a new cycle
            cq_in = nq;
            if (nq == 3'd0) begin
               for (int i = 0; i < NQ; i++) disp_in[i] = '0;
            end
            if (count_ff[nq] == '0 && nq != start_ff) begin
               marks_in[nq] = 1'b1;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_GRANT;
         end
         ST_GRANT: begin
            if (count_ff[cq_ff] != '0) begin
               gv_in   = 1'b1;
               gtag_in = rd_data_ff;
               gcls_in = cq_ff;
               head_in[cq_ff]  = (head_ff[cq_ff] == PTR_W'(QUEUE_DEPTH-1)) ?
                                 '0 : head_ff[cq_ff] + 1'b1;
               count_in[cq_ff] = count_ff[cq_ff] - 1'b1;
               if (disp_ff[cq_ff] < DISP_MAX) disp_in[cq_ff] = disp_ff[cq_ff] + 1'b1;
               marks_in[cq_ff] = 1'b0;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ch.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) tag_mem[mem_waddr] <= req_ch.request_tag;
      rd_data_ff <= tag_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         for (int i = 0; i < NQ; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
            disp_ff[i]  <= '0;
         end
         cq_ff      <= '0;
         start_ff   <= '0;
         scan_ff    <= '0;
         marks_ff   <= '0;
         armed_ff   <= '0;
         wend_ff[0] <= '0;
         wend_ff[1] <= '0;
         time_ff    <= '0;
         pending_ff <= 1'b0;
         cd_ff      <= '0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         count_ff   <= count_in;
         disp_ff    <= disp_in;
         cq_ff      <= cq_in;
         start_ff   <= start_in;
         scan_ff    <= scan_in;
         marks_ff   <= marks_in;
         armed_ff   <= armed_in;
         wend_ff    <= wend_in;
         time_ff    <= time_in;
         pending_ff <= pending_in;
         cd_ff      <= cd_in;
      end
   end

   always_ff @(posedge clock) begin
      gv_ff   <= gv_in;
      gtag_ff <= gtag_in;
      gcls_ff <= gcls_in;
      hold_ff <= hold_in;
      rej_ff  <= rej_in;
   end

   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !rsp_ch.valid) else $error("ready while result waits");

   a_grant_or_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.grant_valid && rsp_ch.idle_hold))
      else $error("grant and idle hold together");

   a_pending_cd: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> (cd_ff != '0)) else $error("idle timer pending at zero");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GRANT) |=> (count_ff[$past(cq_ff)] <= CNT_W'(QUEUE_DEPTH)))
      else $error("queue count overflow");
endmodule
`default_nettype wire

### dv/tb.sv
// Self-checking bench for the read-over-write quantum scheduler core.
// A scoreboard class predicts each result from the accepted items and checks it.
// Depends on rowqs_pkg, rowqs_req_if, rowqs_rsp_if and the core.
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import rowqs_pkg::*;

   typedef struct packed {
      logic             grant_valid;
      logic [TAG_W-1:0] grant_tag;
      logic [2:0]       grant_class;
      logic             idle_hold;
      logic             add_rejected;
   } sched_result_t;

   class sched_scoreboard;
      logic [QUANT_W-1:0] quantum [NQ];
      logic [WAIT_W-1:0]  idle_wait;
      logic [TAG_W-1:0]   tags [NQ*QUEUE_DEPTH];
      int                 head [NQ];
      int                 count [NQ];
      int                 served [NQ];
      int                 cur_q;
      logic [6:0]         unserved;
      logic               armed [2];
      logic [31:0]        window_end [2];
      logic [31:0]        now;
      logic               timer_on;
      int                 countdown;
      sched_result_t      pending_results [$];
      int                 errors;
      int                 grants;
      int                 holds;
      int                 rejects;

      function new();
         for (int i = 0; i < NQ; i++) begin
            quantum[i] = QUANTUM_RESET[i];
            head[i] = 0;
            count[i] = 0;
            served[i] = 0;
         end
         idle_wait = IDLE_WAIT_RESET;
         cur_q = 0;
         unserved = '0;
         armed = '{1'b0, 1'b0};
         window_end = '{32'd0, 32'd0};
         now = '0;
         timer_on = 1'b0;
         countdown = 0;
         errors = 0;
         grants = 0;
         holds = 0;
         rejects = 0;
      endfunction

      function void write_reg(int idx, logic [31:0] val);
         if (idx < NQ) quantum[idx] = val[QUANT_W-1:0];
         else idle_wait = val[WAIT_W-1:0];
      endfunction

      function void step_queue();
         cur_q++;
         if (cur_q >= NQ) begin
            cur_q = 0;
            for (int i = 0; i < NQ; i++) served[i] = 0;
         end
      endfunction

      function bit hop();
         int start;
         bit any;
         start = cur_q;
         any = 0;
         for (int i = 0; i < NQ; i++) if (count[i] != 0) any = 1;
         if (!any) return 0;
         step_queue();
         while (count[cur_q] == 0 && cur_q != start) begin
            unserved[cur_q] = 1'b1;
            step_queue();
         end
         return 1;
      endfunction

      function void grant(ref sched_result_t r);
         int c;
         c = cur_q;
         if (count[c] == 0) return;
         r.grant_valid = 1'b1;
         r.grant_tag = tags[c*QUEUE_DEPTH + head[c]];
         r.grant_class = c[2:0];
         head[c] = (head[c] + 1) % QUEUE_DEPTH;
         count[c]--;
         if (served[c] < 1023) served[c]++;
         unserved[c] = 1'b0;
      endfunction

      function void dispatch(ref sched_result_t r);
         int cq;
         cq = cur_q;
         for (int i = 0; i < cq; i++) begin
            if (unserved[i] && count[i] != 0) begin
               cur_q = i;
               grant(r);
               return;
            end
         end
         if (served[cq] >= quantum[cq]) begin
            served[cq] = 0;
            if (hop()) grant(r);
            return;
         end
         if (count[cq] == 0) begin
            if (timer_on) begin
               r.idle_hold = 1'b1;
               return;
            end
            if (cq < 2 && armed[cq]) begin
               timer_on = 1'b1;
               countdown = (idle_wait != 0) ? idle_wait : 1;
               r.idle_hold = 1'b1;
               return;
            end
            if (!hop()) return;
         end
         grant(r);
      endfunction

      // predict the result of one accepted item
      function void note_item(action_type act, logic [2:0] qc, logic [TAG_W-1:0] tag);
         sched_result_t r;
         logic [31:0] diff;
         int c;
         r = '0;
         c = qc;
         case (act)
            ACT_ADD: begin
               if (c >= NQ || count[c] >= QUEUE_DEPTH) r.add_rejected = 1'b1;
               else begin
                  tags[c*QUEUE_DEPTH + (head[c] + count[c]) % QUEUE_DEPTH] = tag;
                  count[c]++;
                  if (c < 2) begin
                     timer_on = 1'b0;
                     countdown = 0;
                     diff = now - window_end[c];
                     armed[c] = diff[31];
                     window_end[c] = now + READ_WINDOW_TICKS;
                  end
               end
            end
            ACT_DISPATCH: dispatch(r);
            ACT_TICK: begin
               now++;
               if (timer_on) begin
                  if (countdown > 0) countdown--;
                  if (countdown == 0) begin
                     timer_on = 1'b0;
                     if (cur_q < 2) armed[cur_q] = 1'b0;
                  end
               end
            end
            default: ;
         endcase
         pending_results.push_back(r);
      endfunction

      function void check_result(sched_result_t got);
         sched_result_t exp_r;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected item, actual %p", $realtime, got);
            errors++;
            return;
         end
         exp_r = pending_results.pop_front();
         if (got.grant_valid) grants++;
         if (got.idle_hold) holds++;
         if (got.add_rejected) rejects++;
         if (got !== exp_r) begin
            $display("%0t: mismatch, expected %p, actual %p", $realtime, exp_r, got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [PADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   rowqs_req_if req_ch ();
   rowqs_rsp_if rsp_ch ();

   read_over_write_quantum_scheduler_core i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   sched_scoreboard sb = new();
   int cycle_count = 0;
   int rx_hold = 0;    // long stall request for the receiver
   bit rx_random = 1;
   int items_sent = 0;
   localparam int CYCLE_LIMIT = 600000;

   always #1 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.action = ACT_NOP;
      req_ch.queue_class = '0;
      req_ch.request_tag = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic int gap_len();
      return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(3, 30);
   endfunction

   // receiver: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else if (rx_hold > 0) begin
         rsp_ch.ready <= 1'b0;
         rx_hold <= rx_hold - 1;
      end else if (!rx_random) rsp_ch.ready <= 1'b1;
      else rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result({rsp_ch.grant_valid, rsp_ch.grant_tag, rsp_ch.grant_class,
                          rsp_ch.idle_hold, rsp_ch.add_rejected});
   end

   // valid stays high after an accept; the next item with a gap or drain() drops it
   task automatic send_item(action_type act, logic [2:0] qc, logic [TAG_W-1:0] tag,
                            int gap);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= act;
      req_ch.queue_class <= qc;
      req_ch.request_tag <= tag;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_item(act, qc, tag);
      items_sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic csr_write(int idx, logic [31:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= PADDR_W'(4*idx);
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   // mostly well-formed add/dispatch/tick traffic with random content
   task automatic random_phase(int n, int mode);
      int r;
      action_type act;
      logic [2:0] qc;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < 42) act = ACT_ADD;
         else if (r < 80) act = ACT_DISPATCH;
         else if (r < 97) act = ACT_TICK;
         else act = ACT_NOP;
         if (mode == 1 && act == ACT_TICK && $urandom_range(0, 1)) act = ACT_DISPATCH;
         qc = ($urandom_range(0, 40) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
         if (mode == 2 && $urandom_range(0, 1)) qc = 3'($urandom_range(0, 1));
         send_item(act, qc, 16'($urandom), gap_len() * ($urandom_range(0, 4) != 0));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every action, idling, reject on full and class seven
      send_item(ACT_DISPATCH, 3'd0, 16'h0000, 0);
      send_item(ACT_ADD, 3'd0, 16'hFFFF, 0);
      send_item(ACT_ADD, 3'd0, 16'h0000, 0);
      send_item(ACT_DISPATCH, 3'd0, 16'h0000, 0);
      send_item(ACT_DISPATCH, 3'd0, 16'h0000, 0);
      send_item(ACT_DISPATCH, 3'd0, 16'h0000, 0);
      send_item(ACT_DISPATCH, 3'd0, 16'h0000, 0);
      send_item(ACT_TICK, 3'd7, 16'hA5A5, 0);
      send_item(ACT_NOP, 3'd5, 16'h5A5A, 0);
      send_item(ACT_ADD, 3'd7, 16'h1234, 0);
      for (int i = 0; i < 17; i++) send_item(ACT_ADD, 3'd6, 16'(i * 3855), 0);
      drain();

      // back-to-back adds against a long receiver stall
      rx_hold = 150;
      for (int i = 0; i < 20; i++) send_item(ACT_ADD, 3'($urandom_range(0, 6)),
                                            16'($urandom), 0);
      drain();

      random_phase(450, 0);
      drain();
      for (int i = 0; i < NQ; i++) csr_write(i, 32'd0);
      csr_write(7, 32'd0);
      random_phase(350, 1);
      drain();
      for (int i = 0; i < NQ; i++) csr_write(i, 32'd1023);
      csr_write(7, 32'd65535);
      random_phase(300, 2);
      drain();
      for (int i = 0; i < NQ; i++) csr_write(i, $urandom_range(0, 4));
      csr_write(7, $urandom_range(1, 6));
      rx_random = 0;
      random_phase(350, 2);
      rx_random = 1;
      drain();
      for (int i = 0; i < NQ; i++) csr_write(i, $urandom_range(1, 3));
      csr_write(7, 32'd1);
      random_phase(350, 0);
      drain();

      $display("Sent %0d items: %0d grants, %0d idle holds, %0d rejected adds.",
               items_sent, sb.grants, sb.holds, sb.rejects);
      if (sb.errors == 0 && sb.pending_results.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire
